[hdl/dcpe_pkg.sv]
// Shared types and constants for the direction change plane emitter.
package dcpe_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned COS_W   = 31;
  localparam int unsigned OFS_W   = 48;
  localparam int unsigned ACC_W   = 64;

  localparam logic [COS_W-1:0]   COS_LIMIT_RST = 31'd929887697;
  localparam logic [COORD_W-1:0] ONE_Q30       = 32'd1073741824;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DOT,
    ST_CMP,
    ST_SUM,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctl_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } iter_ctl_t;

endpackage

[hdl/dcpe_mac.sv]
// Registered signed multiplier with accumulator.
module dcpe_mac
  import dcpe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [COORD_W-1:0]  a,
  input  logic signed [COORD_W-1:0]  b,
  output logic signed [ACC_W-1:0]    acc
);

  logic signed [ACC_W-1:0] prod_r;
  logic                    pv_r;
  logic signed [ACC_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.en;
    end
    prod_r <= a * b;
    acc_r  <= (ctl.clr ? '0 : acc_r) + (pv_r ? prod_r : '0);
  end

  assign acc = acc_r;

endmodule

[hdl/dcpe_iter.sv]
// Iterative square root and division unit, one result bit per cycle.
module dcpe_iter
  import dcpe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  iter_ctl_t           ctl,
  input  logic [ACC_W-1:0]    arg,
  input  logic [COORD_W-1:0]  den,
  output logic                done,
  output logic [COORD_W-1:0]  res
);

  localparam int unsigned CNT_W = $clog2(COORD_W);

  logic               busy_r;
  logic               done_r;
  logic               div_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ACC_W-1:0]   xs_r;
  logic [ACC_W-1:0]   rr_r;
  logic [ACC_W-1:0]   bit_r;
  logic [COORD_W-1:0] rem_r;
  logic [COORD_W-1:0] lo_r;
  logic [COORD_W-1:0] q_r;
  logic [COORD_W-1:0] den_r;

  logic [ACC_W-1:0]   sq_t;
  logic               sq_ge;
  logic [COORD_W:0]   dv_t;
  logic               dv_ge;
  logic [COORD_W:0]   dv_sub;

  assign sq_t   = rr_r + bit_r;
  assign sq_ge  = xs_r >= sq_t;
  assign dv_t   = {rem_r, lo_r[COORD_W-1]};
  assign dv_ge  = dv_t >= {1'b0, den_r};
  assign dv_sub = dv_t - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(COORD_W - 1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(COORD_W - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
    if (ctl.start) begin
      div_r <= ctl.is_div;
      den_r <= den;
      xs_r  <= arg;
      rr_r  <= '0;
      bit_r <= ACC_W'(1) << (ACC_W - 2);
      rem_r <= arg[ACC_W-1:COORD_W];
      lo_r  <= arg[COORD_W-1:0];
      q_r   <= '0;
    end else if (busy_r) begin
      if (div_r) begin
        rem_r <= dv_ge ? dv_sub[COORD_W-1:0] : dv_t[COORD_W-1:0];
        lo_r  <= {lo_r[COORD_W-2:0], 1'b0};
        q_r   <= {q_r[COORD_W-2:0], dv_ge};
      end else begin
        if (sq_ge) begin
          xs_r <= xs_r - sq_t;
          rr_r <= (rr_r >> 1) + bit_r;
        end else begin
          rr_r <= rr_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign done = done_r;
  assign res  = div_r ? q_r : rr_r[COORD_W-1:0];

endmodule

[hdl/direction_change_plane_emitter.sv]
// Top level: sequencer, state and result register of the plane emitter.
//
//   channel | ports                                   | flow
//   in      | in_valid, in_stall, in_point_x/y/z      | request in
//   out     | out_valid, out_stall, out_normal_x/y/z,  | request out
//           | out_plane_offset                         |
//   cfg     | cfg_wr_en, cfg_wr_data                   | register write
//
// A request runs through magnitude, a shift of the coordinate difference into
// range, squaring, square root, three divisions, dot product and compare, and
// if a plane is emitted offset sum and emit; a point equal to the anchor goes
// back to idle after the magnitude step. The shared unit does one 32-step
// square root, three 32-step divisions. in_stall is high from acceptance until
// the point is done. Reset is synchronous; it clears anchor and direction to
// the origin and +z. A held output stalls the sequencer only in its final step.
module direction_change_plane_emitter
  import dcpe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  in_point_x,
  input  logic signed [COORD_W-1:0]  in_point_y,
  input  logic signed [COORD_W-1:0]  in_point_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  out_normal_x,
  output logic signed [COORD_W-1:0]  out_normal_y,
  output logic signed [COORD_W-1:0]  out_normal_z,
  output logic signed [OFS_W-1:0]    out_plane_offset,
  input  logic                       cfg_wr_en,
  input  logic [COS_W-1:0]           cfg_wr_data
);

  st_t                        st_r, st_nxt;
  logic [2:0]                 cnt_r;
  logic [1:0]                 idx_r;
  logic [1:0]                 sel;
  logic signed [COORD_W-1:0]  p_r   [3];
  logic signed [COORD_W:0]    d_r   [3];
  logic [COORD_W-2:0]         m_r   [3];
  logic [COORD_W-1:0]         len_r;
  logic signed [COORD_W-1:0]  n_r   [3];
  logic signed [COORD_W-1:0]  anc_r [3];
  logic signed [COORD_W-1:0]  dir_r [3];
  logic [COS_W-1:0]           cos_r;
  logic                       out_valid_r;
  logic signed [COORD_W-1:0]  onx_r, ony_r, onz_r;
  logic signed [OFS_W-1:0]    ofs_r;

  logic [COORD_W-1:0]         mag   [3];
  logic                       any31, all0, any30;
  logic                       in_acc, slot_free, emit;
  mac_ctl_t                   mac_ctl;
  iter_ctl_t                  iter_ctl;
  logic signed [COORD_W-1:0]  mac_a, mac_b;
  logic signed [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]           iter_arg;
  logic                       iter_done;
  logic [COORD_W-1:0]         iter_res;
  logic [ACC_W-1:0]           sum_mag;
  logic [ACC_W-1:0]           sum_rnd;
  logic [OFS_W-1:0]           ofs_val;
  logic signed [COORD_W-1:0]  q_sgn;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (st_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign sel       = (cnt_r[1:0] == 2'd3) ? 2'd2 : cnt_r[1:0];
  assign emit      = acc < $signed({3'b000, cos_r, 30'd0});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = d_r[i][COORD_W] ? COORD_W'(-d_r[i]) : d_r[i][COORD_W-1:0];
    end
  end

  assign any31 = mag[0][31] | mag[1][31] | mag[2][31];
  assign all0  = (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
  assign any30 = m_r[0][30] | m_r[1][30] | m_r[2][30];

  assign sum_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign sum_rnd = (sum_mag + (ACC_W'(1) << 29)) >> 30;
  assign ofs_val = acc[ACC_W-1] ? sum_rnd[OFS_W-1:0] : OFS_W'(-sum_rnd);
  assign q_sgn   = d_r[idx_r][COORD_W] ? -$signed(iter_res) : $signed(iter_res);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_acc) st_nxt = ST_MAG;
      ST_MAG:  st_nxt = all0 ? ST_IDLE : ST_NORM;
      ST_NORM: if (any30) st_nxt = ST_SQ;
      ST_SQ:   if (cnt_r == 3'd3) st_nxt = ST_SQRT;
      ST_SQRT: if (iter_done) st_nxt = ST_DIV;
      ST_DIV:  if (iter_done && idx_r == 2'd2) st_nxt = ST_DOT;
      ST_DOT:  if (cnt_r == 3'd3) st_nxt = ST_CMP;
      ST_CMP:  st_nxt = emit ? ST_SUM : ST_IDLE;
      ST_SUM:  if (cnt_r == 3'd3) st_nxt = ST_EMIT;
      ST_EMIT: if (slot_free) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mac_ctl  = '0;
    iter_ctl = '0;
    mac_a    = '0;
    mac_b    = '0;
    iter_arg = '0;
    unique case (st_r)
      ST_SQ: begin
        mac_ctl.en  = (cnt_r < 3'd3);
        mac_ctl.clr = (cnt_r == 3'd0);
        mac_a       = $signed({1'b0, m_r[sel]});
        mac_b       = $signed({1'b0, m_r[sel]});
      end
      ST_SQRT: begin
        iter_ctl.start = (cnt_r == 3'd0);
        iter_arg       = acc;
      end
      ST_DIV: begin
        iter_ctl.start  = (cnt_r == 3'd0);
        iter_ctl.is_div = 1'b1;
        iter_arg        = ({33'd0, m_r[idx_r]} << 30) + ACC_W'(len_r >> 1);
      end
      ST_DOT: begin
        mac_ctl.en  = (cnt_r < 3'd3);
        mac_ctl.clr = (cnt_r == 3'd0);
        mac_a       = n_r[sel];
        mac_b       = dir_r[sel];
      end
      ST_SUM: begin
        mac_ctl.en  = (cnt_r < 3'd3);
        mac_ctl.clr = (cnt_r == 3'd0);
        mac_a       = n_r[sel];
        mac_b       = p_r[sel];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      cos_r       <= COS_LIMIT_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        anc_r[i] <= '0;
      end
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= ONE_Q30;
    end else begin
      st_r <= st_nxt;
      if (cfg_wr_en) begin
        cos_r <= cfg_wr_data;
      end
      if (st_r != st_nxt) begin
        cnt_r <= '0;
      end else if (iter_ctl.start) begin
        cnt_r <= 3'd1;
      end else if (iter_done) begin
        cnt_r <= '0;
      end else if (mac_ctl.en || cnt_r == 3'd3) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (st_r == ST_SQRT) begin
        idx_r <= '0;
      end else if (st_r == ST_DIV && iter_done) begin
        idx_r <= idx_r + 1'b1;
      end
      if (st_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
        for (int i = 0; i < 3; i++) begin
          anc_r[i] <= p_r[i];
          dir_r[i] <= n_r[i];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      p_r[0] <= in_point_x;
      p_r[1] <= in_point_y;
      p_r[2] <= in_point_z;
      d_r[0] <= {in_point_x[31], in_point_x} - {anc_r[0][31], anc_r[0]};
      d_r[1] <= {in_point_y[31], in_point_y} - {anc_r[1][31], anc_r[1]};
      d_r[2] <= {in_point_z[31], in_point_z} - {anc_r[2][31], anc_r[2]};
    end
    if (st_r == ST_MAG) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= any31 ? mag[i][COORD_W-1:1] : mag[i][COORD_W-2:0];
      end
    end else if (st_r == ST_NORM && !any30) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= {m_r[i][COORD_W-3:0], 1'b0};
      end
    end
    if (st_r == ST_SQRT && iter_done) begin
      len_r <= iter_res;
    end
    if (st_r == ST_DIV && iter_done) begin
      n_r[idx_r] <= q_sgn;
    end
    if (st_r == ST_EMIT && slot_free) begin
      onx_r <= n_r[0];
      ony_r <= n_r[1];
      onz_r <= n_r[2];
      ofs_r <= $signed(ofs_val);
    end
  end

  dcpe_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  dcpe_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (iter_ctl),
    .arg   (iter_arg),
    .den   (len_r),
    .done  (iter_done),
    .res   (iter_res)
  );

  assign out_valid        = out_valid_r;
  assign out_normal_x     = onx_r;
  assign out_normal_y     = ony_r;
  assign out_normal_z     = onz_r;
  assign out_plane_offset = ofs_r;

endmodule
